// ===== rtl/lcgp_pkg.sv =====
// ----------------------------------------------------------------------------
// LED crossfade package
// Shared types, constants and the gamma lookup for the five-channel crossfader.
// ----------------------------------------------------------------------------
package lcgp_pkg;

  localparam int CHANNELS   = 5;
  localparam int FADE_STEPS = 400;
  localparam int LVL_W      = 7;
  localparam int DUTY_W     = 11;
  localparam int CNT_W      = $clog2(FADE_STEPS + 1);
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int BIT_W      = $clog2(CNT_W);
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  localparam logic [LVL_W-1:0]  LVL_MAX  = LVL_W'(100);
  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(1024);

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // register index (word address bit)
  localparam logic REG_INSTANT = 1'b0;

  typedef struct packed {
    logic             operation;
    logic [LVL_W-1:0] target_red;
    logic [LVL_W-1:0] target_green;
    logic [LVL_W-1:0] target_blue;
    logic [LVL_W-1:0] target_white_a;
    logic [LVL_W-1:0] target_white_b;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_red;
    logic [DUTY_W-1:0] duty_green;
    logic [DUTY_W-1:0] duty_blue;
    logic [DUTY_W-1:0] duty_white_a;
    logic [DUTY_W-1:0] duty_white_b;
    logic              fade_done;
  } out_item_t;

  localparam logic [DUTY_W-1:0] GAMMA_ROM [0:100] = '{
    11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd1,
    11'd1,   11'd1,   11'd2,   11'd2,   11'd3,   11'd3,   11'd4,   11'd5,
    11'd6,   11'd7,   11'd8,   11'd10,  11'd11,  11'd13,  11'd15,  11'd17,
    11'd19,  11'd21,  11'd24,  11'd26,  11'd29,  11'd32,  11'd35,  11'd39,
    11'd42,  11'd46,  11'd50,  11'd54,  11'd59,  11'd63,  11'd68,  11'd73,
    11'd79,  11'd84,  11'd90,  11'd96,  11'd103, 11'd109, 11'd116, 11'd124,
    11'd131, 11'd139, 11'd147, 11'd155, 11'd164, 11'd173, 11'd182, 11'd192,
    11'd202, 11'd212, 11'd223, 11'd234, 11'd245, 11'd257, 11'd269, 11'd281,
    11'd293, 11'd307, 11'd320, 11'd334, 11'd348, 11'd362, 11'd377, 11'd392,
    11'd408, 11'd424, 11'd441, 11'd458, 11'd475, 11'd493, 11'd511, 11'd529,
    11'd548, 11'd568, 11'd587, 11'd608, 11'd628, 11'd650, 11'd671, 11'd693,
    11'd716, 11'd739, 11'd762, 11'd786, 11'd811, 11'd836, 11'd861, 11'd887,
    11'd913, 11'd940, 11'd968, 11'd996, 11'd1024
  };

  function automatic logic [DUTY_W-1:0] gamma_duty(input logic [LVL_W-1:0] lvl);
    logic [DUTY_W-1:0] d;
    if (lvl > LVL_MAX) begin
      d = DUTY_MAX;
    end else begin
      d = GAMMA_ROM[lvl];
    end
    return d;
  endfunction

  function automatic logic [LVL_W-1:0] sat_level(input logic [LVL_W-1:0] lvl);
    return (lvl > LVL_MAX) ? LVL_MAX : lvl;
  endfunction

endpackage

// ===== rtl/led_crossfade_gamma_pwm.sv =====
// ----------------------------------------------------------------------------
// LED crossfade with gamma-corrected PWM duties
// Five-channel crossfader: starts load targets and, without instant_mode, derive a
// step interval per channel with a shared restoring divider; ticks while fading
// step the channels one at a time; each transaction returns the gamma duties.
// ----------------------------------------------------------------------------
// Path, accept to out_valid: start without instant_mode passes ST_DSET per channel
//   and ST_DRUN (shared divider) per channel with a gap, tick while fading ST_TICK
//   per channel, then ST_OUT, any other item ST_OUT only; a stalled result holds it.
// Throughput: one transaction at a time; in_ready is high only while idle.
// Reset: synchronous active-low rst_n clears levels, targets, intervals, tick count
//   and instant_mode, and leaves the fade done; no clearing pass.
module led_crossfade_gamma_pwm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lcgp_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lcgp_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcgp_pkg::APB_AW-1:0]  paddr,
  input  logic [lcgp_pkg::APB_DW-1:0]  pwdata,
  output logic [lcgp_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import lcgp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DSET = 5'b00010,
    ST_DRUN = 5'b00100,
    ST_TICK = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  localparam logic [CNT_W-1:0] FADE_VEC = CNT_W'(FADE_STEPS);

  state_t             state_r, state_nxt;
  logic               instant_r, instant_nxt;
  logic               fading_r, fading_nxt;
  logic [CNT_W-1:0]   tick_cnt_r, tick_cnt_nxt;
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic [LVL_W-1:0]   lvl_r [CHANNELS];
  logic [LVL_W-1:0]   lvl_nxt [CHANNELS];
  logic [LVL_W-1:0]   tgt_r [CHANNELS];
  logic [LVL_W-1:0]   tgt_nxt [CHANNELS];
  logic [CNT_W-1:0]   mag_r [CHANNELS];
  logic [CNT_W-1:0]   mag_nxt [CHANNELS];
  logic [CNT_W-1:0]   rem_r [CHANNELS];
  logic [CNT_W-1:0]   rem_nxt [CHANNELS];
  logic               up_r [CHANNELS];
  logic               up_nxt [CHANNELS];
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // divider datapath
  logic [LVL_W-1:0]   div_r, div_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   quo_r, quo_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;

  logic [LVL_W-1:0]   tgt_in [CHANNELS];
  logic [LVL_W-1:0]   cur_lvl, cur_tgt;
  logic signed [LVL_W:0] gap;
  logic [LVL_W-1:0]   gap_mag;
  logic [CNT_W:0]     trial, trial_diff;
  logic               trial_ge;
  logic [CNT_W-1:0]   quo_step;
  logic               hit;
  logic [CNT_W-1:0]   rem_inc;
  logic               last_ch;
  logic               cfg_wr;

  assign tgt_in[0] = sat_level(in_data.target_red);
  assign tgt_in[1] = sat_level(in_data.target_green);
  assign tgt_in[2] = sat_level(in_data.target_blue);
  assign tgt_in[3] = sat_level(in_data.target_white_a);
  assign tgt_in[4] = sat_level(in_data.target_white_b);

  assign cur_lvl = lvl_r[ch_r];
  assign cur_tgt = tgt_r[ch_r];
  assign gap     = $signed({1'b0, cur_tgt}) - $signed({1'b0, cur_lvl});
  assign gap_mag = gap[LVL_W] ? LVL_W'(-gap) : LVL_W'(gap);

  // one restoring step: bring down the next dividend bit, try the divisor
  assign trial      = {acc_r, FADE_VEC[bit_r]};
  assign trial_ge   = trial >= (CNT_W+1)'(div_r);
  assign trial_diff = trial - (CNT_W+1)'(div_r);
  assign quo_step   = {quo_r[CNT_W-2:0], trial_ge};

  assign hit     = (mag_r[ch_r] != '0) && (rem_r[ch_r] == '0);
  assign rem_inc = rem_r[ch_r] + CNT_W'(1);
  assign last_ch = (ch_r == CH_W'(CHANNELS - 1));

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_INSTANT);
  assign prdata = (paddr[2] == REG_INSTANT) ? {{(APB_DW-1){1'b0}}, instant_r} : '0;

  always_comb begin
    state_nxt     = state_r;
    instant_nxt   = cfg_wr ? pwdata[0] : instant_r;
    fading_nxt    = fading_r;
    tick_cnt_nxt  = tick_cnt_r;
    ch_nxt        = ch_r;
    lvl_nxt       = lvl_r;
    tgt_nxt       = tgt_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    up_nxt        = up_r;
    div_nxt       = div_r;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ch_nxt    = '0;
          state_nxt = ST_OUT;
          if (in_data.operation == OP_START) begin
            tgt_nxt      = tgt_in;
            tick_cnt_nxt = '0;
            for (int c = 0; c < CHANNELS; c++) begin
              rem_nxt[c] = '0;
            end
            if (instant_r) begin
              lvl_nxt    = tgt_in;
              fading_nxt = 1'b0;
            end else begin
              fading_nxt = 1'b1;
              state_nxt  = ST_DSET;
            end
          end else if (fading_r) begin
            if (instant_r) begin
              lvl_nxt    = tgt_r;
              fading_nxt = 1'b0;
            end else if (tick_cnt_r >= FADE_VEC) begin
              fading_nxt = 1'b0;
            end else begin
              state_nxt = ST_TICK;
            end
          end
        end
      end

      ST_DSET: begin
        up_nxt[ch_r] = !gap[LVL_W];
        div_nxt      = gap_mag;
        acc_nxt      = '0;
        quo_nxt      = '0;
        bit_nxt      = BIT_W'(CNT_W - 1);
        if (gap == '0) begin
          // no gap: channel holds still
          mag_nxt[ch_r] = '0;
          if (last_ch) begin
            state_nxt = ST_OUT;
          end else begin
            ch_nxt = ch_r + CH_W'(1);
          end
        end else begin
          state_nxt = ST_DRUN;
        end
      end

      ST_DRUN: begin
        acc_nxt = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_nxt = quo_step;
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          mag_nxt[ch_r] = quo_step;
          if (last_ch) begin
            state_nxt = ST_OUT;
          end else begin
            ch_nxt    = ch_r + CH_W'(1);
            state_nxt = ST_DSET;
          end
        end
      end

      ST_TICK: begin
        if (hit) begin
          if (up_r[ch_r] && (cur_lvl < LVL_MAX)) begin
            lvl_nxt[ch_r] = cur_lvl + LVL_W'(1);
          end else if (!up_r[ch_r] && (cur_lvl != '0)) begin
            lvl_nxt[ch_r] = cur_lvl - LVL_W'(1);
          end
        end
        // track tick_cnt modulo the interval
        if (mag_r[ch_r] != '0) begin
          rem_nxt[ch_r] = (rem_inc == mag_r[ch_r]) ? '0 : rem_inc;
        end
        if (last_ch) begin
          tick_cnt_nxt = tick_cnt_r + CNT_W'(1);
          state_nxt    = ST_OUT;
        end else begin
          ch_nxt = ch_r + CH_W'(1);
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.duty_red     = gamma_duty(lvl_r[0]);
          out_data_nxt.duty_green   = gamma_duty(lvl_r[1]);
          out_data_nxt.duty_blue    = gamma_duty(lvl_r[2]);
          out_data_nxt.duty_white_a = gamma_duty(lvl_r[3]);
          out_data_nxt.duty_white_b = gamma_duty(lvl_r[4]);
          out_data_nxt.fade_done    = !fading_r;
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      instant_r   <= 1'b0;
      fading_r    <= 1'b0;
      tick_cnt_r  <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        lvl_r[c] <= '0;
        tgt_r[c] <= '0;
        mag_r[c] <= '0;
        rem_r[c] <= '0;
        up_r[c]  <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      instant_r   <= instant_nxt;
      fading_r    <= fading_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
      tgt_r       <= tgt_nxt;
      mag_r       <= mag_nxt;
      rem_r       <= rem_nxt;
      up_r        <= up_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    acc_r      <= acc_nxt;
    quo_r      <= quo_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/lcgp_chk.sv =====
// ----------------------------------------------------------------------------
// LED crossfade port checker
// Watches the top-level ports for handshake and result-range violations.
// ----------------------------------------------------------------------------
module lcgp_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lcgp_pkg::out_item_t out_data
);
  import lcgp_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the block is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // duties stay within the gamma range
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.duty_red <= DUTY_MAX) && (out_data.duty_green <= DUTY_MAX) &&
                  (out_data.duty_blue <= DUTY_MAX) && (out_data.duty_white_a <= DUTY_MAX) &&
                  (out_data.duty_white_b <= DUTY_MAX))
    else $error("duty out of range");

endmodule

bind led_crossfade_gamma_pwm lcgp_chk u_lcgp_chk (.*);
